/* rtl/afp_pkg.sv */
// Shared types and constants of the IMU angle frame parser.
`default_nettype none
package afp_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'h55;
	localparam logic [7:0] HDR_SECOND = 8'h53;
	localparam logic [3:0] FRAME_LEN  = 4'd9;
	localparam int unsigned STORED_BYTES = 8;

	localparam int unsigned AFP_FIFO_DEPTH = 2;

	// angle = trunc(raw * 180 / 32768)
	localparam logic signed [23:0] ANGLE_SCALE = 24'sd180;
	localparam int unsigned ANGLE_SHIFT = 15;
	localparam logic signed [23:0] ANGLE_BIAS = 24'sd32767;

	// temp = trunc(raw * 5 / 17) + 3653; 1/17 as ceil(2^24 / 17), exact for |raw*5| <= 163840
	localparam logic [19:0] TEMP_RECIP = 20'd986896;
	localparam logic signed [15:0] TEMP_OFFSET = 16'sd3653;

	typedef struct packed {
		logic signed [15:0] word_x;
		logic signed [15:0] word_y;
		logic signed [15:0] word_z;
		logic signed [15:0] word_t;
	} frame_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} frame_push_t;

endpackage
`default_nettype wire

/* rtl/afp_front.sv */
// Byte front end: header search, payload capture, frame hand-off.
`default_nettype none
module afp_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_ready,
	input  wire logic [7:0]          rx_byte,
	input  wire logic                queue_full,
	output afp_pkg::frame_push_t     push
);
	import afp_pkg::*;

	logic [7:0] prev_q;
	logic       armed_q;
	logic [3:0] count_q;
	logic [7:0] payload_q [STORED_BYTES];

	logic take;
	logic is_header;
	logic last_byte;

	assign byte_ready = !queue_full;
	assign take       = byte_valid && byte_ready;
	assign is_header  = (rx_byte == HDR_SECOND) && (prev_q == HDR_FIRST);
	assign last_byte  = armed_q && (count_q == FRAME_LEN - 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			armed_q <= 1'b0;
			count_q <= '0;
		end else if (take) begin
			if (is_header) begin
				armed_q <= 1'b1;
				count_q <= '0;
			end else begin
				prev_q <= rx_byte;
				if (armed_q) begin
					count_q <= count_q + 4'd1;
					if (last_byte)
						armed_q <= 1'b0;
				end
			end
		end
	end

	// checksum byte (count 8) is not stored
	always_ff @(posedge clk) begin
		if (take && !is_header && armed_q && !count_q[3])
			payload_q[count_q[2:0]] <= rx_byte;
	end

	always_comb begin
		push.valid        = take && !is_header && last_byte;
		push.frame.word_x = {payload_q[1], payload_q[0]};
		push.frame.word_y = {payload_q[3], payload_q[2]};
		push.frame.word_z = {payload_q[5], payload_q[4]};
		push.frame.word_t = {payload_q[7], payload_q[6]};
	end

endmodule
`default_nettype wire

/* rtl/afp_fifo.sv */
// Short frame queue between the byte front end and the scaling back end.
`default_nettype none
module afp_fifo #(
	parameter int unsigned DEPTH = afp_pkg::AFP_FIFO_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire afp_pkg::frame_push_t push,
	output logic                     full,
	output logic                     head_valid,
	output afp_pkg::frame_t          head,
	input  wire logic                pop
);
	import afp_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	frame_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push.frame;
	end

endmodule
`default_nettype wire

/* rtl/afp_back.sv */
// Scaling back end: three-stage pipeline from raw words to the result register.
`default_nettype none
module afp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire afp_pkg::frame_t  head,
	output logic                  pop,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output logic signed [8:0]     angle_x,
	output logic signed [8:0]     angle_y,
	output logic signed [8:0]     angle_z,
	output logic signed [14:0]    temp_centi,
	output logic signed [9:0]     pitch_deg,
	output logic signed [9:0]     roll_deg
);
	import afp_pkg::*;

	logic adv_out, adv_s2, adv_s1;
	logic valid_s1, valid_s2;

	// stage 1: angle products and |raw_t| * 5
	logic signed [23:0] prod_x_s1, prod_y_s1, prod_z_s1;
	logic [17:0]        tmag5_s1;
	logic               tneg_s1;

	// stage 2: whole-degree angles and temperature quotient
	logic signed [8:0]  ax_s2, ay_s2, az_s2;
	logic [13:0]        tq_s2;
	logic               tneg_s2;

	logic [16:0]        t_mag;
	logic signed [23:0] adj_x, adj_y, adj_z;
	logic [37:0]        t_prod;
	logic signed [15:0] t_signed;

	assign adv_out = !result_valid || result_ready;
	assign adv_s2  = !valid_s2 || adv_out;
	assign adv_s1  = !valid_s1 || adv_s2;
	assign pop     = head_valid && adv_s1;

	assign t_mag = head.word_t[15] ? 17'(-(17'(head.word_t))) : 17'(head.word_t);

	// toward-zero rounding: bias negatives before the arithmetic shift
	assign adj_x = prod_x_s1 + (prod_x_s1[23] ? ANGLE_BIAS : 24'sd0);
	assign adj_y = prod_y_s1 + (prod_y_s1[23] ? ANGLE_BIAS : 24'sd0);
	assign adj_z = prod_z_s1 + (prod_z_s1[23] ? ANGLE_BIAS : 24'sd0);
	assign t_prod = 38'(tmag5_s1) * 38'(TEMP_RECIP);

	assign t_signed = tneg_s2 ? -(16'(tq_s2)) : 16'(tq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= head_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
			if (adv_out)
				result_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			prod_x_s1 <= 24'(head.word_x) * ANGLE_SCALE;
			prod_y_s1 <= 24'(head.word_y) * ANGLE_SCALE;
			prod_z_s1 <= 24'(head.word_z) * ANGLE_SCALE;
			tmag5_s1  <= 18'({t_mag, 2'b00}) + 18'(t_mag);
			tneg_s1   <= head.word_t[15];
		end
		if (adv_s2) begin
			ax_s2   <= adj_x[23:ANGLE_SHIFT];
			ay_s2   <= adj_y[23:ANGLE_SHIFT];
			az_s2   <= adj_z[23:ANGLE_SHIFT];
			tq_s2   <= t_prod[37:24];
			tneg_s2 <= tneg_s1;
		end
		if (adv_out) begin
			angle_x    <= ax_s2;
			angle_y    <= ay_s2;
			angle_z    <= az_s2;
			temp_centi <= 15'(t_signed + TEMP_OFFSET);
			pitch_deg  <= 10'(ax_s2) - 10'(ay_s2);
			roll_deg   <= 10'(ax_s2) + 10'(ay_s2);
		end
	end

endmodule
`default_nettype wire

/* rtl/imu_angle_frame_parser.sv */
// Top level of the IMU angle frame parser.
`default_nettype none
// Takes one received byte per cycle on the byte channel and hunts for the header pair
// 0x55 0x53; the nine bytes after a header form a frame (the ninth, the checksum, is not
// checked). Each complete frame yields one result: X/Y/Z angles in whole degrees, the
// temperature in hundredths of a degree C, and pitch (X-Y) and roll (X+Y). A header seen
// mid-frame restarts the frame. Bytes are taken every cycle as long as the frame queue
// (FIFO_DEPTH entries) has room; a frame's result passes from the queue write through
// two scaling stages to the result register, and the scaling pipeline sustains one
// result per cycle while result_ready is high, so a stalled result port only backs up
// into the byte port once the queue and pipeline are full.
module imu_angle_frame_parser #(
	parameter int unsigned FIFO_DEPTH = afp_pkg::AFP_FIFO_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          byte_valid,
	output logic               byte_ready,
	input  wire logic [7:0]    rx_byte,
	output logic               result_valid,
	input  wire logic          result_ready,
	output logic signed [8:0]  angle_x,
	output logic signed [8:0]  angle_y,
	output logic signed [8:0]  angle_z,
	output logic signed [14:0] temp_centi,
	output logic signed [9:0]  pitch_deg,
	output logic signed [9:0]  roll_deg
);
	import afp_pkg::*;

	frame_push_t push;
	frame_t      head;
	logic        queue_full;
	logic        head_valid;
	logic        pop;

	afp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.rx_byte    (rx_byte),
		.queue_full (queue_full),
		.push       (push)
	);

	afp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	afp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.angle_x      (angle_x),
		.angle_y      (angle_y),
		.angle_z      (angle_z),
		.temp_centi   (temp_centi),
		.pitch_deg    (pitch_deg),
		.roll_deg     (roll_deg)
	);

endmodule
`default_nettype wire

/* tb/sv/imu_angle_frame_parser_tb.sv */
// Testbench for imu_angle_frame_parser: byte stream in, scaled angle frames out, self-checked.
module imu_angle_frame_parser_tb;
	import afp_pkg::*;

	typedef struct packed {
		logic signed [8:0]  angle_x;
		logic signed [8:0]  angle_y;
		logic signed [8:0]  angle_z;
		logic signed [14:0] temp_centi;
		logic signed [9:0]  pitch_deg;
		logic signed [9:0]  roll_deg;
	} angles_t;

	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		angles_t    angles;
	} byte_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               byte_valid = 1'b0;
	logic               byte_ready;
	logic [7:0]         rx_byte = 8'h00;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic signed [8:0]  angle_x;
	logic signed [8:0]  angle_y;
	logic signed [8:0]  angle_z;
	logic signed [14:0] temp_centi;
	logic signed [9:0]  pitch_deg;
	logic signed [9:0]  roll_deg;

	// parser shadow state
	logic [7:0] frame_prev = 8'h00;
	logic       frame_armed = 1'b0;
	logic [3:0] frame_count = 4'd0;
	logic [7:0] frame_payload [STORED_BYTES];

	angles_t pending_angles [$];
	int      mismatches = 0;
	int      frames_predicted = 0;
	bit      no_idle = 1'b0;

	// header handling, extremes, resync; typed results on the two checksum rows
	byte_row_t directed_rows [26] = '{
		'{8'h53, 1'b0, '0},
		'{HDR_FIRST, 1'b0, '0},
		'{HDR_SECOND, 1'b0, '0},
		'{HDR_SECOND, 1'b0, '0},
		'{8'hFF, 1'b0, '0}, '{8'h7F, 1'b0, '0},
		'{8'h00, 1'b0, '0}, '{8'h80, 1'b0, '0},
		'{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'hFF, 1'b0, '0}, '{8'h7F, 1'b0, '0},
		'{HDR_FIRST, 1'b1, '{179, -180, 0, 13290, 359, -1}},
		'{HDR_SECOND, 1'b0, '0},
		'{8'h12, 1'b0, '0},
		'{HDR_FIRST, 1'b0, '0},
		'{HDR_SECOND, 1'b0, '0},
		'{8'h00, 1'b0, '0}, '{8'h80, 1'b0, '0},
		'{8'hFF, 1'b0, '0}, '{8'h7F, 1'b0, '0},
		'{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
		'{8'h00, 1'b0, '0}, '{8'h80, 1'b0, '0},
		'{8'h00, 1'b1, '{-180, 179, 0, -5984, -359, -1}}
	};

	imu_angle_frame_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.rx_byte(rx_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.angle_x(angle_x),
		.angle_y(angle_y),
		.angle_z(angle_z),
		.temp_centi(temp_centi),
		.pitch_deg(pitch_deg),
		.roll_deg(roll_deg)
	);

	always #5 clk = ~clk;

	function automatic int raw_word(input int lo);
		logic signed [15:0] w;
		w = {frame_payload[lo + 1], frame_payload[lo]};
		return w;
	endfunction

	function automatic bit advance_frame(input logic [7:0] b, output angles_t res);
		int ax, ay, az, tc;
		res = '0;
		// second header byte does not become the previous byte
		if (b == HDR_SECOND && frame_prev == HDR_FIRST) begin
			frame_armed = 1'b1;
			frame_count = 4'd0;
			return 1'b0;
		end
		frame_prev = b;
		if (!frame_armed)
			return 1'b0;
		if (frame_count < STORED_BYTES)
			frame_payload[frame_count[2:0]] = b;
		frame_count = frame_count + 4'd1;
		if (frame_count != FRAME_LEN)
			return 1'b0;
		frame_armed = 1'b0;
		ax = (raw_word(0) * 180) / 32768;
		ay = (raw_word(2) * 180) / 32768;
		az = (raw_word(4) * 180) / 32768;
		tc = (raw_word(6) * 100) / 340 + 3653;
		res.angle_x = 9'(ax);
		res.angle_y = 9'(ay);
		res.angle_z = 9'(az);
		res.temp_centi = 15'(tc);
		res.pitch_deg = 10'(ax - ay);
		res.roll_deg = 10'(ax + ay);
		return 1'b1;
	endfunction

	function automatic int idle_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (no_idle || pick < 60)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 2);
		if (pick < 95)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic [15:0] random_word();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit use_typed, input angles_t typed_res);
		int gap;
		angles_t res;
		gap = idle_cycles();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		if (advance_frame(b, res)) begin
			pending_angles.push_back(use_typed ? typed_res : res);
			frames_predicted++;
		end
	endtask

	task automatic send_header();
		send_byte(HDR_FIRST, 1'b0, '0);
		send_byte(HDR_SECOND, 1'b0, '0);
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 2)) send_byte(HDR_SECOND, 1'b0, '0);
	endtask

	task automatic pause_until_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (pending_angles.size() != 0) @(posedge clk);
	endtask

	initial begin
		int items, kind, n;
		bit pressed;
		logic [7:0] frame [9];
		logic [15:0] w;
		items = 0;
		pressed = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].angles);
		pause_until_drained();

		while (items < 500 || frames_predicted < 40) begin
			no_idle = ($urandom_range(0, 4) == 0);
			if (!pressed && items >= 250) begin
				pause_until_drained();
				pressed = 1'b1;
			end
			kind = $urandom_range(0, 99);
			if (kind < 15) begin
				n = $urandom_range(1, 5);
				repeat (n) send_byte(8'($urandom), 1'b0, '0);
				items += n;
			end else begin
				for (int k = 0; k < 4; k++) begin
					w = random_word();
					frame[2 * k] = w[7:0];
					frame[2 * k + 1] = w[15:8];
				end
				// checksum sometimes starts the next header
				frame[8] = ($urandom_range(0, 4) == 0) ? HDR_FIRST : 8'($urandom);
				send_header();
				// truncated frames are cut off by the next header unless later random bytes complete them
				n = (kind < 30) ? $urandom_range(0, 8) : 9;
				for (int k = 0; k < n; k++)
					send_byte(frame[k], 1'b0, '0);
				items += n + 2;
			end
		end
		no_idle = 1'b0;
		byte_valid <= 1'b0;

		while (pending_angles.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		int pick, hold;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				result_ready <= 1'b1;
				hold = $urandom_range(1, 30);
			end else begin
				result_ready <= 1'b0;
				if (pick < 85)
					hold = $urandom_range(1, 3);
				else if (pick < 95)
					hold = $urandom_range(4, 10);
				else
					hold = $urandom_range(20, 60);
			end
			repeat (hold) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		angles_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_angles.size() == 0) begin
				$error("result transfer with no frame pending");
				mismatches++;
			end else begin
				want = pending_angles.pop_front();
				check_field("angle_x", want.angle_x, angle_x);
				check_field("angle_y", want.angle_y, angle_y);
				check_field("angle_z", want.angle_z, angle_z);
				check_field("temp_centi", want.temp_centi, temp_centi);
				check_field("pitch_deg", want.pitch_deg, pitch_deg);
				check_field("roll_deg", want.roll_deg, roll_deg);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
